/* hw/rtl/b64d_pkg.sv */
package b64d_pkg;

	localparam int unsigned ADDR_BITS = 16;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned SEXTET_W = 6;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned REG_W    = 16;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [COUNT_W-1:0] ADDR_MASK = (ADDR_BITS >= COUNT_W) ?
		{COUNT_W{1'b1}} : COUNT_W'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic [6:0] NO_SYMBOL   = 7'd64;
	localparam logic [6:0] PLUS_VALUE  = 7'd62;
	localparam logic [6:0] SLASH_VALUE = 7'd63;

	localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

	typedef enum logic [0:0] {
		CFG_START_OFFSET  = 1'b0,
		CFG_BUFFER_LENGTH = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		PHASE_FIRST  = 2'd0,
		PHASE_SECOND = 2'd1,
		PHASE_THIRD  = 2'd2,
		PHASE_FOURTH = 2'd3
	} phase_t;

	typedef struct packed {
		logic               end_of_string;
		logic [COUNT_W-1:0] byte_count;
		logic               overflow;
		logic               bad_char;
		logic [COUNT_W-1:0] write_address;
		logic               has_byte;
		logic [CHAR_W-1:0]  data_byte;
	} result_t;

	function automatic logic [6:0] sextet_of(input logic [CHAR_W-1:0] c);
		logic [6:0] v;
		v = NO_SYMBOL;
		if (c >= CHAR_UA && c <= CHAR_UZ) begin
			v = 7'(c - CHAR_UA);
		end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
			v = 7'(c - CHAR_LA) + 7'd26;
		end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
			v = 7'(c - CHAR_D0) + 7'd52;
		end else if (c == CHAR_PLUS) begin
			v = PLUS_VALUE;
		end else if (c == CHAR_SLASH) begin
			v = SLASH_VALUE;
		end
		return v;
	endfunction

endpackage

/* hw/rtl/b64d_core.sv */
module b64d_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [b64d_pkg::CHAR_W-1:0]     char_code,
	input  logic                            final_char,
	input  logic [b64d_pkg::REG_W-1:0]      start_offset,
	input  logic [b64d_pkg::REG_W-1:0]      buffer_length,
	output logic                            report,
	output b64d_pkg::result_t               res
);

	b64d_pkg::phase_t                      phase_q, phase_n;
	logic [b64d_pkg::SEXTET_W-1:0]         held_q, held_n;
	logic [b64d_pkg::COUNT_W-1:0]          count_q, count_n;
	logic                                  pad_q, pad_n;
	logic                                  bad_q, bad_n;
	logic                                  ovf_q, ovf_n;

	logic [6:0]                            sx;
	logic [b64d_pkg::CHAR_W-1:0]           byte_v;
	logic                                  produced;
	logic [b64d_pkg::COUNT_W:0]            full;
	logic                                  fits;

	assign sx   = b64d_pkg::sextet_of(char_code);
	assign full = {1'b0, start_offset} + {1'b0, count_q};
	assign fits = full < {1'b0, buffer_length};

	always_comb begin
		phase_n  = phase_q;
		held_n   = held_q;
		count_n  = count_q;
		pad_n    = pad_q;
		bad_n    = bad_q;
		ovf_n    = ovf_q;
		byte_v   = '0;
		produced = 1'b0;
		report   = final_char;
		res      = '0;
		if (!pad_q) begin
			if (char_code == b64d_pkg::CHAR_PAD) begin
				pad_n = 1'b1;
			end else if (sx == b64d_pkg::NO_SYMBOL) begin
				bad_n  = 1'b1;
				report = 1'b1;
			end else begin
				produced = 1'b1;
				unique case (phase_q)
					b64d_pkg::PHASE_FIRST: begin
						held_n   = sx[5:0];
						produced = 1'b0;
					end
					b64d_pkg::PHASE_SECOND: begin
						byte_v = {held_q[5:0], sx[5:4]};
						held_n = {2'b00, sx[3:0]};
					end
					b64d_pkg::PHASE_THIRD: begin
						byte_v = {held_q[3:0], sx[5:2]};
						held_n = {4'b0000, sx[1:0]};
					end
					default: begin
						byte_v = {held_q[1:0], sx[5:0]};
						held_n = '0;
					end
				endcase
				phase_n = b64d_pkg::phase_t'(phase_q + 2'd1);
				if (produced) begin
					report = 1'b1;
					if (fits) begin
						res.has_byte      = 1'b1;
						res.data_byte     = byte_v;
						res.write_address = full[b64d_pkg::COUNT_W-1:0] & b64d_pkg::ADDR_MASK;
						count_n           = count_q + 16'd1;
					end else begin
						ovf_n = 1'b1;
					end
				end
			end
		end
		res.bad_char      = bad_n;
		res.overflow      = ovf_n;
		res.byte_count    = count_n;
		res.end_of_string = final_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64d_pkg::PHASE_FIRST;
			held_q  <= '0;
			count_q <= '0;
			pad_q   <= 1'b0;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (go) begin
			if (final_char) begin
				phase_q <= b64d_pkg::PHASE_FIRST;
				held_q  <= '0;
				count_q <= '0;
				pad_q   <= 1'b0;
				bad_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				held_q  <= held_n;
				count_q <= count_n;
				pad_q   <= pad_n;
				bad_q   <= bad_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && final_char |=> phase_q == b64d_pkg::PHASE_FIRST && count_q == '0 && !pad_q)
		else $error("string state not cleared after final character");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.has_byte |-> res.byte_count == count_q + 16'd1 && !ovf_n)
		else $error("written byte does not advance count by one");

	a_pad_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		go && pad_q && !final_char |=> $stable(count_q) && $stable(phase_q))
		else $error("decoding advanced after padding");

	a_drop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> !res.has_byte)
		else $error("byte written after an overflow in the same string");

endmodule

/* hw/rtl/base64_char_decoder.sv */
// Channel | Dir | tdata                                   | tlast         | tuser
// s_*     | in  | [7:0] char_code                         | final_char    | -
// m_*     | out | [7:0] data_byte, [8] has_byte,          | end_of_string | -
//         |     | [24:9] write_address, [25] bad_char,    |               |
//         |     | [26] overflow, [42:27] byte_count       |               |
// cfg_*   | in  | index 0 start_offset, 1 buffer_length   | -             | -
//
// One character per cycle sustained while m_tready does not stall; a character passes
// the input register and then the result register on its way to m_* valid.
// arst_n clears all string state, both configuration registers and valids.
// A character that yields no result retires without touching the m_* side.
// A stall on m_tready holds the result and, once the input register holds a
// character that needs a result, stops further transfers on s_*.
module base64_char_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] char_code
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [b64d_pkg::OUT_TDATA_W-1:0]    m_tdata,   // data_byte, has_byte,
	                                                       // write_address, bad_char,
	                                                       // overflow, byte_count
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [b64d_pkg::REG_W-1:0]          cfg_data
);

	logic [b64d_pkg::REG_W-1:0]  start_offset_q;
	logic [b64d_pkg::REG_W-1:0]  buffer_length_q;

	logic                        valid_s1;
	logic [7:0]                  char_s1;
	logic                        final_s1;

	logic                        out_valid_q;
	b64d_pkg::result_t           out_res_q;

	logic                        report;
	b64d_pkg::result_t           res;
	logic                        out_free;
	logic                        go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_offset_q  <= '0;
			buffer_length_q <= '0;
		end else if (cfg_we) begin
			unique case (b64d_pkg::cfg_index_t'(cfg_index))
				b64d_pkg::CFG_START_OFFSET:  start_offset_q  <= cfg_data;
				b64d_pkg::CFG_BUFFER_LENGTH: buffer_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign go       = valid_s1 && (!report || out_free);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	b64d_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.char_code     (char_s1),
		.final_char    (final_s1),
		.start_offset  (start_offset_q),
		.buffer_length (buffer_length_q),
		.report        (report),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && report) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && report) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_res_q.end_of_string;
	assign m_tdata  = {5'b00000,
	                   out_res_q.byte_count,
	                   out_res_q.overflow,
	                   out_res_q.bad_char,
	                   out_res_q.write_address,
	                   out_res_q.has_byte,
	                   out_res_q.data_byte};

endmodule

/* tb/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_MAX   = 40;

	typedef struct {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic [15:0] write_address;
		logic        bad_char;
		logic        overflow;
		logic [15:0] byte_count;
		logic        end_of_string;
	} decoded_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [7:0]                       s_tdata   = '0;
	logic                             s_tlast   = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [b64d_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tlast;
	logic                             cfg_we    = 1'b0;
	logic [0:0]                       cfg_index = '0;
	logic [b64d_pkg::REG_W-1:0]       cfg_data  = '0;

	decoded_t          pending_q[$];
	logic [6:0]        sym_table[256];
	b64d_pkg::phase_t  grp_phase;
	logic [5:0]        carry_bits;
	logic [15:0]       out_count;
	logic              pad_hit;
	logic              bad_flag;
	logic              ovf_flag;
	logic [15:0]       base_addr;
	logic [15:0]       buf_len;
	bit                calm         = 1'b0;
	int                errors       = 0;
	int                chars_sent   = 0;
	int                strings_sent = 0;
	int                results_seen = 0;
	longint            cycles       = 0;

	base64_char_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [7:0] alpha_char(input int idx);
		if (idx < 26) return b64d_pkg::CHAR_UA + 8'(idx);
		if (idx < 52) return b64d_pkg::CHAR_LA + 8'(idx - 26);
		if (idx < 62) return b64d_pkg::CHAR_D0 + 8'(idx - 52);
		return (idx == 62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
	endfunction

	task automatic clear_string();
		grp_phase  = b64d_pkg::PHASE_FIRST;
		carry_bits = '0;
		out_count  = '0;
		pad_hit    = 1'b0;
		bad_flag   = 1'b0;
		ovf_flag   = 1'b0;
	endtask

	task automatic predict_char(input logic [7:0] c, input logic fin);
		decoded_t    r;
		logic [6:0]  v;
		logic [7:0]  b;
		logic [16:0] full;
		logic        emit;
		logic        produced;
		emit            = fin;
		produced        = 1'b0;
		b               = '0;
		r.data_byte     = '0;
		r.has_byte      = 1'b0;
		r.write_address = '0;
		if (!pad_hit) begin
			v = sym_table[c];
			if (c == b64d_pkg::CHAR_PAD) begin
				pad_hit = 1'b1;
			end else if (v == b64d_pkg::NO_SYMBOL) begin
				bad_flag = 1'b1;
				emit     = 1'b1;
			end else begin
				case (grp_phase)
					b64d_pkg::PHASE_FIRST: begin
						carry_bits = v[5:0];
					end
					b64d_pkg::PHASE_SECOND: begin
						b          = {carry_bits, v[5:4]};
						carry_bits = {2'b00, v[3:0]};
						produced   = 1'b1;
					end
					b64d_pkg::PHASE_THIRD: begin
						b          = {carry_bits[3:0], v[5:2]};
						carry_bits = {4'b0000, v[1:0]};
						produced   = 1'b1;
					end
					default: begin
						b          = {carry_bits[1:0], v[5:0]};
						carry_bits = '0;
						produced   = 1'b1;
					end
				endcase
				grp_phase = b64d_pkg::phase_t'(2'(grp_phase + 1));
				if (produced) begin
					emit = 1'b1;
					full = {1'b0, base_addr} + {1'b0, out_count};
					if (full < {1'b0, buf_len}) begin
						r.has_byte      = 1'b1;
						r.data_byte     = b;
						r.write_address = full[15:0] & b64d_pkg::ADDR_MASK;
						out_count       = out_count + 16'd1;
					end else begin
						ovf_flag = 1'b1;
					end
				end
			end
		end
		if (emit) begin
			r.bad_char      = bad_flag;
			r.overflow      = ovf_flag;
			r.byte_count    = out_count;
			r.end_of_string = fin;
			pending_q.push_back(r);
		end
		if (fin) clear_string();
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= REPORT_MAX)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
	endtask

	task automatic compare_field(input string what, input longint got, input longint want);
		if (got != want) report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		decoded_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = pending_q.pop_front();
				compare_field("data_byte", m_tdata[7:0], want.data_byte);
				compare_field("has_byte", m_tdata[8], want.has_byte);
				compare_field("write_address", m_tdata[24:9], want.write_address);
				compare_field("bad_char", m_tdata[25], want.bad_char);
				compare_field("overflow", m_tdata[26], want.overflow);
				compare_field("byte_count", m_tdata[42:27], want.byte_count);
				compare_field("tdata fill", m_tdata[b64d_pkg::OUT_TDATA_W-1:43], 0);
				compare_field("end_of_string", m_tlast, want.end_of_string);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_q.size());
			$display("** base64_char_decoder: FAILED **");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_char(input logic [7:0] c, input logic fin);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		predict_char(c, fin);
		chars_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] start, input logic [15:0] len);
		cfg_we    <= 1'b1;
		cfg_index <= b64d_pkg::CFG_START_OFFSET;
		cfg_data  <= start;
		@(posedge clk);
		cfg_index <= b64d_pkg::CFG_BUFFER_LENGTH;
		cfg_data  <= len;
		@(posedge clk);
		cfg_we    <= 1'b0;
		base_addr = start;
		buf_len   = len;
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
		strings_sent++;
	endtask

	task automatic send_random_string();
		logic [7:0] text[$];
		int         kind;
		int         len;
		int         pick;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			repeat ($urandom_range(0, 8) * 4) text.push_back(alpha_char($urandom_range(0, 63)));
			case ($urandom_range(0, 2))
				1: begin
					repeat (2) text.push_back(alpha_char($urandom_range(0, 63)));
					repeat (2) text.push_back(b64d_pkg::CHAR_PAD);
				end
				2: begin
					repeat (3) text.push_back(alpha_char($urandom_range(0, 63)));
					text.push_back(b64d_pkg::CHAR_PAD);
				end
				default: ;
			endcase
			if (text.size() == 0) text.push_back(alpha_char($urandom_range(0, 63)));
		end else if (kind <= 8) begin
			len = $urandom_range(1, 30);
			repeat (len) begin
				pick = $urandom_range(0, 19);
				if (pick <= 2) text.push_back(8'($urandom_range(0, 255)));
				else if (pick == 3) text.push_back(b64d_pkg::CHAR_PAD);
				else text.push_back(alpha_char($urandom_range(0, 63)));
			end
		end else begin
			len = $urandom_range(1, 10);
			repeat (len) text.push_back(8'($urandom_range(0, 255)));
		end
		send_text(text);
	endtask

	task automatic test_directed_chars();
		set_config(16'h0000, 16'hFFFF);
		send_text('{"T", "W", "F", "u", "/", "+", 8'h00, "9", "z", 8'hFF, "A", "0", "Q",
			b64d_pkg::CHAR_PAD, "B", 8'h80});
		send_text('{"A"});
		send_text('{b64d_pkg::CHAR_PAD});
		wait_idle();
	endtask

	task automatic test_overflow_edges();
		set_config(16'hFFFE, 16'hFFFF);
		send_text('{"/", "/", "/", "/"});
		wait_idle();
		set_config(16'hFFFF, 16'h0000);
		send_text('{"A", "B"});
		wait_idle();
	endtask

	task automatic test_random_strings(input logic [15:0] start, input logic [15:0] len,
		input int count);
		int first;
		set_config(start, len);
		first = chars_sent;
		while (chars_sent - first < count) send_random_string();
		wait_idle();
	endtask

	task automatic test_no_idle_tail(input int count);
		calm = 1'b1;
		test_random_strings(16'($urandom_range(0, 255)), 16'hFFFF, count);
	endtask

	initial begin
		for (int i = 0; i < 256; i++) sym_table[i] = b64d_pkg::NO_SYMBOL;
		for (int i = 0; i < 64; i++) sym_table[alpha_char(i)] = 7'(i);
		clear_string();
		base_addr = '0;
		buf_len   = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_chars();
		test_overflow_edges();
		test_random_strings(16'h0000, 16'hFFFF, 130);
		test_random_strings(16'hFFFF, 16'hFFFF, 100);
		test_random_strings(16'($urandom_range(0, 65535)), 16'h0000, 80);
		test_random_strings(16'h0100, 16'h0110, 130);
		test_random_strings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 130);
		test_no_idle_tail(150);

		$display("Sent %0d characters in %0d strings; %0d results checked, %0d mismatches.",
			chars_sent, strings_sent, results_seen, errors);
		$display("Covered padding, bad characters, overflow and offset/length extremes.");
		if (errors == 0) begin
			$display("** base64_char_decoder: PASSED **");
		end else begin
			$display("** base64_char_decoder: FAILED **");
		end
		$finish;
	end

endmodule
